[rtl/core/diff_drive_odometry_assert.svh]
// Assertion macros shared by the odometry checker.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("odometry assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

`endif

[rtl/core/ddo_pkg.sv]
// Package with widths, constants, types and the arctangent table of the odometry block.
package ddo_pkg;

    localparam int RPM_W     = 16;
    localparam int CFG_W     = 16;
    localparam int POS_W     = 32;
    localparam int ANG_W     = 16;
    localparam int MUL_A_W   = 29;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int RES_W     = 32;
    localparam int SH_W      = 5;
    localparam int CFG_IDX_W = 2;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_COUNT = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_TRACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

    localparam logic [CFG_W-1:0] WHEEL_RADIUS_RST  = 16'd5898;
    localparam logic [CFG_W-1:0] INVERSE_TRACK_RST = 16'd10114;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd3277;

    // 2*pi/60 in Q24, 65536/(2*pi) in Q8, pi in Q28, CORDIC gain in Q30.
    localparam logic [MUL_B_W-1:0] K_RPM_TO_RADS = 32'd1756906;
    localparam logic [MUL_B_W-1:0] K_BAM_PER_RAD = 32'd2670177;
    localparam logic [MUL_B_W-1:0] K_PI_Q28      = 32'd843314857;
    localparam logic [RES_W-1:0]   CORDIC_GAIN   = 32'd652032874;

    localparam logic [SH_W-1:0] SH_RATE  = 5'd12;
    localparam logic [SH_W-1:0] SH_RAD   = 5'd17;
    localparam logic [SH_W-1:0] SH_TRACK = 5'd12;
    localparam logic [SH_W-1:0] SH_TIME  = 5'd16;
    localparam logic [SH_W-1:0] SH_BAM   = 5'd24;
    localparam logic [SH_W-1:0] SH_ANGLE = 5'd13;
    localparam logic [SH_W-1:0] SH_TRIG  = 5'd30;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [SH_W-1:0]    shift;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic             flip;
        logic [RES_W-1:0] z;
    } t_cordic_req;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] cos_v;
        logic [RES_W-1:0] sin_v;
    } t_cordic_res;

    // atan(2^-i) in radians, Q30.
    function automatic logic [RES_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [RES_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048576;
            5'd11:   v = 32'd524288;
            5'd12:   v = 32'd262144;
            5'd13:   v = 32'd131072;
            5'd14:   v = 32'd65536;
            5'd15:   v = 32'd32768;
            5'd16:   v = 32'd16384;
            5'd17:   v = 32'd8192;
            5'd18:   v = 32'd4096;
            5'd19:   v = 32'd2048;
            5'd20:   v = 32'd1024;
            5'd21:   v = 32'd512;
            5'd22:   v = 32'd256;
            5'd23:   v = 32'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/ddo_if.sv]
// Valid/ready stream interfaces for the tick items and the pose results.
interface ddo_in_if import ddo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [RPM_W-1:0] right_rpm;
    logic signed [RPM_W-1:0] left_rpm;

    modport source (output valid, output mode, output right_rpm, output left_rpm, input ready);
    modport sink   (input valid, input mode, input right_rpm, input left_rpm, output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0]        heading;
    logic                    saturated;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output saturated, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input saturated, output ready);
endinterface

[rtl/core/ddo_mul_rnd.sv]
// Shared signed multiplier with a registered product and a round-half-up shift.
module ddo_mul_rnd import ddo_pkg::*; (
    input  logic             i_clk,
    input  t_mul_req         i_req,
    output logic [RES_W-1:0] o_res
);

    logic signed [MUL_P_W-1:0] r_prod;
    logic [SH_W-1:0]           r_shift;
    logic signed [MUL_P_W-1:0] w_half;
    logic signed [MUL_P_W-1:0] w_sum;
    logic signed [MUL_P_W-1:0] w_shifted;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod  <= $signed(i_req.a) * $signed(i_req.b);
            r_shift <= i_req.shift;
        end
    end

    // The product is registered, so the rounding add sits in the following cycle.
    assign w_half    = $signed({{(MUL_P_W-1){1'b0}}, 1'b1}) <<< (r_shift - 5'd1);
    assign w_sum     = r_prod + w_half;
    assign w_shifted = w_sum >>> r_shift;
    assign o_res     = w_shifted[RES_W-1:0];

endmodule

[rtl/core/ddo_cordic.sv]
// Iterative rotation-mode CORDIC that turns an angle into cosine and sine.
module ddo_cordic import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_res o_res
);

    localparam int RUN_STEPS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int STEP_W    = (RUN_STEPS > 1) ? $clog2(RUN_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RUN_STEPS - 1);

    logic                    r_busy, n_busy;
    logic                    r_fix, n_fix;
    logic                    r_done, n_done;
    logic                    r_flip, n_flip;
    logic [STEP_W-1:0]       r_step, n_step;
    logic signed [RES_W-1:0] r_x, n_x;
    logic signed [RES_W-1:0] r_y, n_y;
    logic signed [RES_W-1:0] r_z, n_z;
    logic signed [RES_W-1:0] w_xs, w_ys, w_atan;

    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = $signed(atan_q30(ATAN_IDX_W'(r_step)));

    always_comb begin
        n_busy = r_busy;
        n_fix  = 1'b0;
        n_done = 1'b0;
        n_flip = r_flip;
        n_step = r_step;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_flip = i_req.flip;
            n_step = '0;
            n_x    = $signed(CORDIC_GAIN);
            n_y    = '0;
            n_z    = $signed(i_req.z);
        end else if (r_busy) begin
            if (!r_z[RES_W-1]) begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_fix  = 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end else if (r_fix) begin
            // Angles folded by half a turn come back by negating both results.
            if (r_flip) begin
                n_x = -r_x;
                n_y = -r_y;
            end
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fix  <= n_fix;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flip <= n_flip;
        r_step <= n_step;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_x;
    assign o_res.sin_v = r_y;

endmodule

[rtl/core/diff_drive_odometry.sv]
// Top level of the differential-drive dead-reckoning odometry block.
//
// Each tick transfer on i_in carries right and left wheel speeds in rpm (signed Q12.4);
// the block turns them into a linear speed and a turn rate, moves x and y by the
// travelled distance along the heading held before the tick, advances the heading and
// then offers the new pose (Q16.16 metres, 16-bit binary angle) as one transfer on
// o_out. A tick with mode set clears the pose and returns an all-zero result. All
// eleven products of a tick go through one shared multiplier, each as a registered
// product and then a rounding step, and the heading's cosine and sine come from an
// iterative CORDIC. A tick is accepted only while the block is idle, so it occupies
// the block until its pose has been moved to the output register; a clearing tick
// goes straight there. x and y saturate at the signed 32-bit limits and the
// saturated flag reports it; the heading wraps. The output register holds a result
// until it is taken, so the next tick can be accepted in the meantime. The user must
// write the registers through the i_cfg_* port only while the block is idle; the
// block itself does not enforce this. Index 0 wheel radius (Q0.16 m), 1 inverse track
// (Q4.12 1/m), 2 sample period (Q0.16 s); writes to other indexes are ignored.
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ddo_in_if.sink               i_in,
    ddo_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_CORD = 3'd3;
    localparam logic [2:0] S_ACCX = 3'd4;
    localparam logic [2:0] S_ACCY = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // Steps of the multiply program, in issue order.
    localparam logic [3:0] OP_SUM  = 4'd0;
    localparam logic [3:0] OP_DIF  = 4'd1;
    localparam logic [3:0] OP_V    = 4'd2;
    localparam logic [3:0] OP_T    = 4'd3;
    localparam logic [3:0] OP_W    = 4'd4;
    localparam logic [3:0] OP_DIST = 4'd5;
    localparam logic [3:0] OP_DANG = 4'd6;
    localparam logic [3:0] OP_BAM  = 4'd7;
    localparam logic [3:0] OP_Z    = 4'd8;
    localparam logic [3:0] OP_DX   = 4'd9;
    localparam logic [3:0] OP_DY   = 4'd10;

    logic [2:0]                r_state, n_state;
    logic [3:0]                r_op, n_op;
    logic [CFG_W-1:0]          r_radius, n_radius;
    logic [CFG_W-1:0]          r_inv, n_inv;
    logic [CFG_W-1:0]          r_period, n_period;
    logic signed [POS_W-1:0]   r_x, n_x;
    logic signed [POS_W-1:0]   r_y, n_y;
    logic [ANG_W-1:0]          r_head, n_head;
    logic                      r_sat, n_sat;
    logic                      r_out_valid, n_out_valid;

    logic [RPM_W-1:0]          r_right, n_right;
    logic [RPM_W-1:0]          r_left, n_left;
    logic [MUL_A_W-1:0]        r_ra, n_ra;
    logic [MUL_A_W-1:0]        r_rb, n_rb;
    logic [ANG_W-1:0]          r_dbam, n_dbam;
    logic [POS_W-1:0]          r_out_x, n_out_x;
    logic [POS_W-1:0]          r_out_y, n_out_y;
    logic [ANG_W-1:0]          r_out_head, n_out_head;
    logic                      r_out_sat, n_out_sat;

    t_mul_req                  w_mul_req;
    logic [RES_W-1:0]          w_mul_res;
    t_cordic_req               w_cord_req;
    t_cordic_res               w_cord_res;

    logic [RPM_W:0]            w_sum17;
    logic [RPM_W:0]            w_dif17;
    logic                      w_flip;
    logic [ANG_W-1:0]          w_angle;
    logic signed [POS_W:0]     w_acc_sum;
    logic                      w_acc_ovf;
    logic [POS_W-1:0]          w_acc_val;

    assign w_sum17 = {r_right[RPM_W-1], r_right} + {r_left[RPM_W-1], r_left};
    assign w_dif17 = {r_right[RPM_W-1], r_right} - {r_left[RPM_W-1], r_left};

    // The CORDIC only covers the right half plane: headings in the left half are
    // taken half a turn away and the results negated. Toggling the sign bit in that
    // case leaves bit 14 copied into bit 15.
    assign w_flip  = r_head[ANG_W-1] ^ r_head[ANG_W-2];
    assign w_angle = {r_head[ANG_W-2], r_head[ANG_W-2:0]};

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_req.en    = (r_state == S_MUL);
        w_mul_req.a     = '0;
        w_mul_req.b     = '0;
        w_mul_req.shift = SH_RATE;
        case (r_op)
            OP_SUM: begin
                w_mul_req.a     = {{(MUL_A_W-RPM_W-1){w_sum17[RPM_W]}}, w_sum17};
                w_mul_req.b     = K_RPM_TO_RADS;
                w_mul_req.shift = SH_RATE;
            end
            OP_DIF: begin
                w_mul_req.a     = {{(MUL_A_W-RPM_W-1){w_dif17[RPM_W]}}, w_dif17};
                w_mul_req.b     = K_RPM_TO_RADS;
                w_mul_req.shift = SH_RATE;
            end
            OP_V: begin
                w_mul_req.a     = r_ra;
                w_mul_req.b     = {{(MUL_B_W-CFG_W){1'b0}}, r_radius};
                w_mul_req.shift = SH_RAD;
            end
            OP_T: begin
                w_mul_req.a     = r_rb;
                w_mul_req.b     = {{(MUL_B_W-CFG_W){1'b0}}, r_radius};
                w_mul_req.shift = SH_RAD;
            end
            OP_W: begin
                w_mul_req.a     = r_rb;
                w_mul_req.b     = {{(MUL_B_W-CFG_W){1'b0}}, r_inv};
                w_mul_req.shift = SH_TRACK;
            end
            OP_DIST: begin
                w_mul_req.a     = r_ra;
                w_mul_req.b     = {{(MUL_B_W-CFG_W){1'b0}}, r_period};
                w_mul_req.shift = SH_TIME;
            end
            OP_DANG: begin
                w_mul_req.a     = r_rb;
                w_mul_req.b     = {{(MUL_B_W-CFG_W){1'b0}}, r_period};
                w_mul_req.shift = SH_TIME;
            end
            OP_BAM: begin
                w_mul_req.a     = r_rb;
                w_mul_req.b     = K_BAM_PER_RAD;
                w_mul_req.shift = SH_BAM;
            end
            OP_Z: begin
                w_mul_req.a     = {{(MUL_A_W-ANG_W){w_angle[ANG_W-1]}}, w_angle};
                w_mul_req.b     = K_PI_Q28;
                w_mul_req.shift = SH_ANGLE;
            end
            OP_DX: begin
                w_mul_req.a     = r_ra;
                w_mul_req.b     = w_cord_res.cos_v;
                w_mul_req.shift = SH_TRIG;
            end
            OP_DY: begin
                w_mul_req.a     = r_ra;
                w_mul_req.b     = w_cord_res.sin_v;
                w_mul_req.shift = SH_TRIG;
            end
            default: begin
                w_mul_req.a     = '0;
                w_mul_req.b     = '0;
                w_mul_req.shift = SH_RATE;
            end
        endcase
    end

    // The angle product goes straight into the CORDIC as its start value.
    assign w_cord_req.start = (r_state == S_RND) && (r_op == OP_Z);
    assign w_cord_req.flip  = w_flip;
    assign w_cord_req.z     = w_mul_res;

    ddo_mul_rnd u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_res (w_mul_res)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cord_req),
        .o_res   (w_cord_res)
    );

    // One saturating adder serves both axes; r_rb holds dx, then dy.
    assign w_acc_sum = (r_state == S_ACCX) ?
                       ({r_x[POS_W-1], r_x} + {{(POS_W+1-MUL_A_W){r_rb[MUL_A_W-1]}}, r_rb}) :
                       ({r_y[POS_W-1], r_y} + {{(POS_W+1-MUL_A_W){r_rb[MUL_A_W-1]}}, r_rb});
    assign w_acc_ovf = w_acc_sum[POS_W] ^ w_acc_sum[POS_W-1];
    assign w_acc_val = w_acc_ovf ? (w_acc_sum[POS_W] ? POS_MIN : POS_MAX)
                                 : w_acc_sum[POS_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_radius    = r_radius;
        n_inv       = r_inv;
        n_period    = r_period;
        n_x         = r_x;
        n_y         = r_y;
        n_head      = r_head;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        n_right     = r_right;
        n_left      = r_left;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_dbam      = r_dbam;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_head  = r_out_head;
        n_out_sat   = r_out_sat;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WHEEL_RADIUS:  n_radius = i_cfg_data;
                REG_INVERSE_TRACK: n_inv    = i_cfg_data;
                REG_SAMPLE_PERIOD: n_period = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_right = i_in.right_rpm;
                    n_left  = i_in.left_rpm;
                    n_sat   = 1'b0;
                    if (i_in.mode) begin
                        n_x     = '0;
                        n_y     = '0;
                        n_head  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_op    = OP_SUM;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_RND;
            end
            S_RND: begin
                case (r_op)
                    OP_SUM, OP_V, OP_DIST: n_ra = w_mul_res[MUL_A_W-1:0];
                    OP_BAM:                n_dbam = w_mul_res[ANG_W-1:0];
                    OP_Z:                  ;
                    default:               n_rb = w_mul_res[MUL_A_W-1:0];
                endcase
                case (r_op)
                    OP_Z:    n_state = S_CORD;
                    OP_DX:   n_state = S_ACCX;
                    OP_DY:   n_state = S_ACCY;
                    default: begin
                        n_op    = r_op + 4'd1;
                        n_state = S_MUL;
                    end
                endcase
            end
            S_CORD: begin
                if (w_cord_res.done) begin
                    n_op    = OP_DX;
                    n_state = S_MUL;
                end
            end
            S_ACCX: begin
                n_x     = w_acc_val;
                n_sat   = r_sat | w_acc_ovf;
                n_op    = OP_DY;
                n_state = S_MUL;
            end
            S_ACCY: begin
                n_y     = w_acc_val;
                n_sat   = r_sat | w_acc_ovf;
                n_head  = r_head + r_dbam;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait here while the previous result still sits in the output register.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_x;
                    n_out_y     = r_y;
                    n_out_head  = r_head;
                    n_out_sat   = r_sat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SUM;
            r_radius    <= WHEEL_RADIUS_RST;
            r_inv       <= INVERSE_TRACK_RST;
            r_period    <= SAMPLE_PERIOD_RST;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_radius    <= n_radius;
            r_inv       <= n_inv;
            r_period    <= n_period;
            r_x         <= n_x;
            r_y         <= n_y;
            r_head      <= n_head;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_right    <= n_right;
        r_left     <= n_left;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_dbam     <= n_dbam;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_head <= n_out_head;
        r_out_sat  <= n_out_sat;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.pos_x     = r_out_x;
    assign o_out.pos_y     = r_out_y;
    assign o_out.heading   = r_out_head;
    assign o_out.saturated = r_out_sat;

endmodule

[rtl/core/ddo_checker.sv]
// Port-level checker for the odometry block, bound to the top level.
`include "diff_drive_odometry_assert.svh"

module ddo_checker import ddo_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [POS_W-1:0] i_pos_x,
    input logic [POS_W-1:0] i_pos_y,
    input logic [ANG_W-1:0] i_heading,
    input logic             i_saturated
);

    // A result that is not taken stays offered unchanged.
    `DDO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_heading) && $stable(i_saturated))

    // The block works on one tick at a time.
    `DDO_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A clipped result sits on a rail of the position range.
    `DDO_ASSERT_NOW(a_sat_on_rail, i_clk, i_rst_n, i_out_valid && i_saturated, i_pos_x == POS_MAX || i_pos_x == POS_MIN || i_pos_y == POS_MAX || i_pos_y == POS_MIN)

    // A new result appears only at the end of a busy period.
    `DDO_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x),
    .i_pos_y     (o_out.pos_y),
    .i_heading   (o_out.heading),
    .i_saturated (o_out.saturated)
);

[tb/tb_diff_drive_odometry.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the differential-drive odometry block.
module tb_diff_drive_odometry;
    import ddo_pkg::*;

    localparam int TRIG_STEPS  = CORDIC_STEPS_DEF;
    localparam int STALL_LIMIT = 2000;

    // The register port has room for a fourth index that maps to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Scale factors of the pose arithmetic, held as signed 64-bit values so that every
    // product below stays signed.
    localparam longint RPM_TO_RADS_Q24 = 64'sd1756906;
    localparam longint BAM_PER_RAD_Q8  = 64'sd2670177;
    localparam longint PI_Q28          = 64'sd843314857;
    localparam longint TRIG_GAIN_Q30   = 64'sd652032874;
    localparam longint POS_HI          = 64'sd2147483647;
    localparam longint POS_LO          = -64'sd2147483648;

    // atan(2^-i) in radians, Q30.
    localparam longint ATAN_RAD_Q30 [ATAN_COUNT] = '{
        843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef struct packed {
        logic                    mode;
        logic signed [RPM_W-1:0] right_rpm;
        logic signed [RPM_W-1:0] left_rpm;
    } t_tick;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [ANG_W-1:0]        heading;
        logic                    saturated;
    } t_pose;

    // One row of the directed table. Where known is set, the pose in the row is the
    // expected result as is; otherwise the pose predictor supplies it.
    typedef struct packed {
        t_tick tick;
        logic  known;
        t_pose want;
    } t_dir_row;

    typedef enum int {RX_OPEN, RX_COIN, RX_LONG, RX_SPARSE} t_rx_style;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Standing still right after reset: the pose stays at the origin.
        '{'{1'b0, 16'h0000, 16'h0000}, 1'b1, '0},
        // Full speed forward and backward, then the two fastest turns.
        '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
        '{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h8000, 16'h7FFF}, 1'b0, '0},
        // Smallest speeds and alternating bit patterns.
        '{'{1'b0, 16'h0001, 16'h0000}, 1'b0, '0},
        '{'{1'b0, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{1'b0, 16'h5555, 16'hAAAA}, 1'b0, '0},
        // A clear returns an all-zero pose whatever the wheel speeds say.
        '{'{1'b1, 16'h7FFF, 16'h8000}, 1'b1, '0},
        '{'{1'b0, 16'h0000, 16'h0000}, 1'b1, '0},
        // Turns that carry the heading past a quarter turn, so the sine and cosine
        // come from the mirrored half of the circle, then past a full turn.
        '{'{1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h4000, 16'h4000}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{1'b0, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{1'b0, 16'h1234, 16'h1200}, 1'b0, '0},
        // Back-to-back clears.
        '{'{1'b1, 16'h0000, 16'h0000}, 1'b1, '0},
        '{'{1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '0},
        '{'{1'b0, 16'h0000, 16'h0000}, 1'b1, '0},
        // A clockwise turn wraps the heading below zero, then drive along it.
        '{'{1'b0, 16'h8000, 16'h7FFF}, 1'b0, '0},
        '{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ddo_in_if  tick_bus ();
    ddo_out_if pose_bus ();

    diff_drive_odometry #(
        .CORDIC_STEPS (TRIG_STEPS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_bus),
        .o_out      (pose_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the pose and of the registers, advanced by the predictor.
    logic signed [POS_W-1:0] est_x;
    logic signed [POS_W-1:0] est_y;
    logic [ANG_W-1:0]        est_heading;
    logic [CFG_W-1:0]        radius_q16;
    logic [CFG_W-1:0]        inv_track_q12;
    logic [CFG_W-1:0]        period_q16;

    // Predicted poses in transfer order, oldest first.
    t_pose pending_poses [$];
    t_pose want_pose;

    int mismatches    = 0;
    int ticks_sent    = 0;
    int clears_sent   = 0;
    int poses_checked = 0;
    int clipped_seen  = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    bit pace_on       = 1'b0;

    int        rx_cycle = 0;
    int        rx_run   = 0;
    logic      rx_level = 1'b1;
    t_rx_style rx_style;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Round half up: floor((v + 2^(s-1)) / 2^s). The arithmetic shift of a signed
    // value is a floor division.
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Cosine and sine of a binary angle, Q30, by a rotation-mode CORDIC. Angles in the
    // back half of the circle are turned by half a turn first and the results negated.
    function automatic void heading_trig(input logic [ANG_W-1:0] ang,
                                         output longint cos_v, output longint sin_v);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        a    = longint'($signed(ang));
        flip = 1'b0;
        if (a >= 16384) begin
            a    = a - 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a    = a + 32768;
            flip = 1'b1;
        end
        z = rnd_shift(a * PI_Q28, 13);
        x = TRIG_GAIN_Q30;
        y = 0;
        for (int i = 0; i < TRIG_STEPS && i < ATAN_COUNT; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_RAD_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_RAD_Q30[i];
            end
            x = nx;
        end
        cos_v = flip ? -x : x;
        sin_v = flip ? -y : y;
    endfunction

    // Clips a sum at the signed 32-bit limits; clipping raises the flag.
    function automatic logic signed [POS_W-1:0] clip_pos(input longint v, inout bit clipped);
        if (v > POS_HI) begin
            clipped = 1'b1;
            return POS_MAX;
        end
        if (v < POS_LO) begin
            clipped = 1'b1;
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    // Advances the shadow pose by one tick and returns the pose the block must report.
    function automatic t_pose integrate_tick(input t_tick t);
        t_pose  res;
        longint r;
        longint l;
        longint rate_sum;
        longint rate_diff;
        longint v;
        longint w;
        longint travel;
        longint dang;
        longint dbam;
        longint c;
        longint s;
        bit     clipped;
        clipped = 1'b0;
        if (t.mode) begin
            est_x       = '0;
            est_y       = '0;
            est_heading = '0;
        end else begin
            r         = longint'($signed(t.right_rpm));
            l         = longint'($signed(t.left_rpm));
            rate_sum  = rnd_shift((r + l) * RPM_TO_RADS_Q24, 12);
            rate_diff = rnd_shift((r - l) * RPM_TO_RADS_Q24, 12);
            v         = rnd_shift(rate_sum * longint'(radius_q16), 17);
            w         = rnd_shift(rnd_shift(rate_diff * longint'(radius_q16), 17)
                                  * longint'(inv_track_q12), 12);
            travel    = rnd_shift(v * longint'(period_q16), 16);
            dang      = rnd_shift(w * longint'(period_q16), 16);
            dbam      = rnd_shift(dang * BAM_PER_RAD_Q8, 24);
            // The move follows the heading held before this tick.
            heading_trig(est_heading, c, s);
            est_x       = clip_pos(longint'(est_x) + rnd_shift(travel * c, 30), clipped);
            est_y       = clip_pos(longint'(est_y) + rnd_shift(travel * s, 30), clipped);
            est_heading = est_heading + dbam[ANG_W-1:0];
        end
        res.pos_x     = est_x;
        res.pos_y     = est_y;
        res.heading   = est_heading;
        res.saturated = clipped;
        return res;
    endfunction

    // Offers one tick and waits for its transfer. With pacing on, the ticks go out in
    // bursts of random length separated by idle gaps, long ones now and then so that a
    // gap can outlast the block's whole computation.
    task automatic push_tick(input t_tick t, input bit known, input t_pose want);
        t_pose calc;
        if (pace_on) begin
            if (burst_left == 0) begin
                tick_bus.valid <= 1'b0;
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 8)) begin
                    @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        tick_bus.valid     <= 1'b1;
        tick_bus.mode      <= t.mode;
        tick_bus.right_rpm <= t.right_rpm;
        tick_bus.left_rpm  <= t.left_rpm;
        do begin
            @(posedge i_clk);
        end while (!tick_bus.ready);
        calc = integrate_tick(t);
        pending_poses.push_back(known ? want : calc);
        ticks_sent++;
        if (t.mode) begin
            clears_sent++;
        end
    endtask

    // Holds the sender back until every predicted pose has been transferred, which
    // leaves the block idle.
    task automatic wait_idle();
        tick_bus.valid <= 1'b0;
        while (pending_poses.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes the three registers on consecutive cycles, plus a write to the unused
    // index that must leave all of them alone.
    task automatic write_settings(input logic [CFG_W-1:0] radius,
                                  input logic [CFG_W-1:0] track,
                                  input logic [CFG_W-1:0] period);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WHEEL_RADIUS;
        i_cfg_data <= radius;
        @(posedge i_clk);
        i_cfg_idx  <= REG_INVERSE_TRACK;
        i_cfg_data <= track;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SAMPLE_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx  <= REG_UNUSED;
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        radius_q16    = radius;
        inv_track_q12 = track;
        period_q16    = period;
        settings_used++;
    endtask

    // Fully random ticks: about one in sixteen is a clear, and one in four of the rest
    // has nearly equal wheel speeds so the base goes roughly straight.
    task automatic mixed_ticks(input int count);
        t_tick t;
        repeat (count) begin
            t.mode      = ($urandom_range(0, 15) == 0);
            t.right_rpm = RPM_W'($urandom);
            t.left_rpm  = ($urandom_range(0, 3) == 0)
                          ? t.right_rpm ^ RPM_W'($urandom_range(0, 15))
                          : RPM_W'($urandom);
            push_tick(t, 1'b0, '0);
        end
    endtask

    // Long straight runs near full speed. In a long phase the first run goes forward
    // from the origin along the x axis and the second backward, far enough to clip x
    // at both limits; later runs start with a random turn and may start with a clear.
    task automatic drive_ticks(input int count);
        t_tick                   t;
        logic signed [RPM_W-1:0] speed;
        int                      seg;
        int                      run;
        int                      sent;
        seg  = 0;
        sent = 0;
        while (sent < count) begin
            if (seg < 2 || $urandom_range(0, 3) == 0) begin
                t = '{1'b1, RPM_W'($urandom), RPM_W'($urandom)};
                push_tick(t, 1'b0, '0);
                sent++;
            end
            if (seg >= 2) begin
                t = '{1'b0, RPM_W'($urandom), RPM_W'($urandom)};
                push_tick(t, 1'b0, '0);
                sent++;
            end
            speed = RPM_W'($urandom_range(16'h7800, 16'h7FFF));
            if (seg == 1 || (seg >= 2 && $urandom_range(0, 1) == 1)) begin
                speed = ~speed;
            end
            run = (seg < 2 && count >= 300) ? 170 : $urandom_range(20, 80);
            repeat (run) begin
                t = '{1'b0, speed, speed};
                if (seg >= 2 && $urandom_range(0, 7) == 0) begin
                    t.left_rpm = speed + RPM_W'($urandom_range(0, 6)) - RPM_W'(3);
                end
                push_tick(t, 1'b0, '0);
                sent++;
            end
            seg++;
        end
    endtask

    // Drains the block, loads a register setting and runs one batch of random ticks.
    task automatic run_phase(input logic [CFG_W-1:0] radius,
                             input logic [CFG_W-1:0] track,
                             input logic [CFG_W-1:0] period,
                             input bit drive, input int count, input bit paced);
        wait_idle();
        write_settings(radius, track, period);
        pace_on = paced;
        if (drive) begin
            drive_ticks(count);
        end else begin
            mixed_ticks(count);
        end
    endtask

    // Compares one field; X or Z on the block's side counts as a mismatch. Reports are
    // capped so that a badly broken block does not flood the log.
    function automatic void check_field(input string field,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 60) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
            end
        end
    endfunction

    // Result side: each pose transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pose_bus.valid && pose_bus.ready) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                $error("pose transfer with no prediction pending: x=%0d y=%0d heading=%0d",
                       pose_bus.pos_x, pose_bus.pos_y, pose_bus.heading);
            end else begin
                want_pose = pending_poses.pop_front();
                check_field("pos_x", want_pose.pos_x, pose_bus.pos_x);
                check_field("pos_y", want_pose.pos_y, pose_bus.pos_y);
                check_field("heading", {48'd0, want_pose.heading}, {48'd0, pose_bus.heading});
                check_field("saturated", {63'd0, want_pose.saturated},
                            {63'd0, pose_bus.saturated});
                poses_checked++;
                if (want_pose.saturated) begin
                    clipped_seen++;
                end
            end
        end
    end

    // Result side back-pressure. The pattern steps through four styles in turn: always
    // ready, a coin toss per cycle, long stalls, and rare short stalls.
    always @(posedge i_clk) begin
        if (rx_run <= 0) begin
            rx_style = t_rx_style'((rx_cycle / 500) % 4);
            case (rx_style)
                RX_OPEN: begin
                    rx_level = 1'b1;
                    rx_run   = 50;
                end
                RX_COIN: begin
                    rx_level = ($urandom_range(0, 1) == 1);
                    rx_run   = 1;
                end
                RX_LONG: begin
                    rx_level = ~rx_level;
                    rx_run   = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 30);
                end
                default: begin
                    rx_level = ($urandom_range(0, 7) != 0);
                    rx_run   = $urandom_range(1, 5);
                end
            endcase
        end
        rx_run--;
        rx_cycle++;
        pose_bus.ready <= rx_level;
    end

    // Watchdog: a run of cycles with no transfer on either side means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_bus.valid && tick_bus.ready)
                || (pose_bus.valid && pose_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d poses still pending",
                     quiet_cycles, pending_poses.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        tick_bus.valid     <= 1'b0;
        tick_bus.mode      <= 1'b0;
        tick_bus.right_rpm <= '0;
        tick_bus.left_rpm  <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_WHEEL_RADIUS;
        i_cfg_data         <= '0;
        i_rst_n            <= 1'b0;
        est_x         = '0;
        est_y         = '0;
        est_heading   = '0;
        radius_q16    = WHEEL_RADIUS_RST;
        inv_track_q12 = INVERSE_TRACK_RST;
        period_q16    = SAMPLE_PERIOD_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the register values left by reset, sent back to back.
        pace_on = 1'b0;
        for (int k = 0; k < DIR_ROWS; k++) begin
            push_tick(DIRECTED[k].tick, DIRECTED[k].known, DIRECTED[k].want);
        end

        // Random phases, each under its own register setting: all at the maximum (where
        // the position clips), all zero (nothing moves), the reset values, two random
        // settings and a tiny wheel with the longest period.
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 400, 1'b1);
        run_phase(16'h0000, 16'h0000, 16'h0000, 1'b0, 40, 1'b0);
        run_phase(WHEEL_RADIUS_RST, INVERSE_TRACK_RST, SAMPLE_PERIOD_RST, 1'b0, 120, 1'b1);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b0, 70, 1'b1);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b1, 70, 1'b0);
        run_phase(16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, 40, 1'b1);

        // Let the last pose arrive, then give a stray extra transfer time to show up.
        wait_idle();
        repeat (TRIG_STEPS + 48) @(posedge i_clk);

        $display("Sent %0d ticks, %0d of them pose clears, under %0d register settings.",
                 ticks_sent, clears_sent, settings_used);
        $display("Compared %0d poses; %0d had x or y clipped at the range limit.",
                 poses_checked, clipped_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
